// ===== src/mmc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the column-major matrix multiply core.
// Holds sizes, operation and register codes, pipeline tag type and helpers; no dependencies.
package mmc_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_BITS = 16;
    localparam int PROD_BITS = 2 * ELEM_BITS + 2;
    localparam int ACC_W     = PROD_BITS + 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CFG_W     = 4;
    localparam int IDX_W     = 2;
    localparam int POS_W     = 6;
    localparam int RC_W      = 3;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    localparam logic [IDX_W-1:0] REG_A_ROWS    = 2'd0;
    localparam logic [IDX_W-1:0] REG_INNER_LEN = 2'd1;
    localparam logic [IDX_W-1:0] REG_B_COLS    = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } tag_t;

    localparam logic signed [ACC_W-1:0] PROD_MAX = {2'b00, {(PROD_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] PROD_MIN = {2'b11, {(PROD_BITS - 1){1'b0}}};

    // A dimension of zero acts as one, and one above the maximum acts as the maximum.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] v;
        v = r;
        if (r == '0)
        begin
            v = CFG_W'(1);
        end
        else if (r > CFG_W'(MAX_DIM))
        begin
            v = CFG_W'(MAX_DIM);
        end
        return v;
    endfunction

endpackage

// ===== src/matrix_multiply_colmajor_core.sv =====
`timescale 1ns / 1ps
// Column-major matrix multiply core: two element stores, a read, multiply and accumulate pipe.
// Depends on mmc_pkg.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  item in  | op, position, element                     | start high while busy low
//  result   | product, out_row, out_col, last           | strobe, one cycle each
//  config   | wr_index, wr_data                         | wr_en, taken at once
//
// A load item leaves busy low, so loads may follow every cycle while no compute item holds busy high.
// A compute item keeps busy high while it runs: one multiply-accumulate
// per cycle, set by the single read port of each store.
// Results leave as strobes and cannot be stalled; busy falls with the final result.
// Reset clears the control state and sets every dimension to 8; the stores are not cleared.
module matrix_multiply_colmajor_core
    import mmc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  op,
    input  logic [POS_W-1:0]            position,
    input  logic signed [ELEM_BITS-1:0] element,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_index,
    input  logic [CFG_W-1:0]            wr_data,
    output logic                        strobe,
    output logic signed [PROD_BITS-1:0] product,
    output logic [RC_W-1:0]             out_row,
    output logic [RC_W-1:0]             out_col,
    output logic                        last
);

    logic [CFG_W-1:0] a_rows_reg, inner_len_reg, b_cols_reg;
    logic [CFG_W-1:0] dim_m, dim_k, dim_n;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next, row_reg, row_next, col_reg, col_next;
    logic busy_reg, busy_next;

    logic [ELEM_BITS-1:0] store_a [DEPTH];
    logic [ELEM_BITS-1:0] store_b [DEPTH];
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic signed [ELEM_BITS-1:0] rd_a_reg, rd_b_reg;
    logic signed [2*ELEM_BITS-1:0] mul_reg;
    logic signed [ACC_W-1:0] acc_reg, sum;

    tag_t tag0, tag1_reg, tag2_reg;
    logic accept, issue, is_i_end, is_row_end, is_col_end, pos_ok;

    logic                        strobe_reg, last_reg;
    logic signed [PROD_BITS-1:0] product_reg;
    logic [DIM_W-1:0]            out_row_reg, out_col_reg;

    assign accept = start && !busy_reg;
    assign pos_ok = {1'b0, position} < (POS_W + 1)'(DEPTH);
    assign dim_m  = eff_dim(a_rows_reg);
    assign dim_k  = eff_dim(inner_len_reg);
    assign dim_n  = eff_dim(b_cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= CFG_W'(8);
            inner_len_reg <= CFG_W'(8);
            b_cols_reg    <= CFG_W'(8);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_A_ROWS:    a_rows_reg    <= wr_data;
                REG_INNER_LEN: inner_len_reg <= wr_data;
                REG_B_COLS:    b_cols_reg    <= wr_data;
                default:       ;
            endcase
        end
    end

    assign is_i_end   = CFG_W'(i_reg) == dim_k - CFG_W'(1);
    assign is_row_end = CFG_W'(row_reg) == dim_m - CFG_W'(1);
    assign is_col_end = CFG_W'(col_reg) == dim_n - CFG_W'(1);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        busy_next  = busy_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_COMPUTE)
                begin
                    state_next = ST_RUN;
                    busy_next  = 1'b1;
                    i_next     = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RUN:
            begin
                issue = 1'b1;
                if (!is_i_end)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    i_next = '0;
                    if (!is_row_end)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        row_next = '0;
                        if (!is_col_end)
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (tag2_reg.valid && tag2_reg.lastk && tag2_reg.last)
        begin
            busy_next = 1'b0;
        end
    end

    assign addr_a = ADDR_W'(i_reg) * ADDR_W'(dim_m) + ADDR_W'(row_reg);
    assign addr_b = ADDR_W'(col_reg) * ADDR_W'(dim_k) + ADDR_W'(i_reg);

    assign tag0.valid = issue;
    assign tag0.first = i_reg == '0;
    assign tag0.lastk = is_i_end;
    assign tag0.last  = is_row_end && is_col_end;
    assign tag0.row   = row_reg;
    assign tag0.col   = col_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD_A && pos_ok)
        begin
            store_a[position[ADDR_W-1:0]] <= element;
        end
        if (accept && op == OP_LOAD_B && pos_ok)
        begin
            store_b[position[ADDR_W-1:0]] <= element;
        end
        rd_a_reg <= store_a[addr_a];
        rd_b_reg <= store_b[addr_b];
    end

    assign sum = (tag2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(mul_reg);

    always_ff @(posedge clk)
    begin
        mul_reg <= rd_a_reg * rd_b_reg;
        if (tag2_reg.valid)
        begin
            acc_reg <= sum;
        end
        if (sum > PROD_MAX)
        begin
            product_reg <= PROD_MAX[PROD_BITS-1:0];
        end
        else if (sum < PROD_MIN)
        begin
            product_reg <= PROD_MIN[PROD_BITS-1:0];
        end
        else
        begin
            product_reg <= sum[PROD_BITS-1:0];
        end
        out_row_reg <= tag2_reg.row;
        out_col_reg <= tag2_reg.col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            i_reg      <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            i_reg      <= i_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            tag1_reg   <= tag0;
            tag2_reg   <= tag1_reg;
            strobe_reg <= tag2_reg.valid && tag2_reg.lastk;
            last_reg   <= tag2_reg.valid && tag2_reg.lastk && tag2_reg.last;
        end
    end

    assign busy    = busy_reg;
    assign strobe  = strobe_reg;
    assign last    = last_reg;
    assign product = product_reg;
    assign out_row = RC_W'(out_row_reg);
    assign out_col = RC_W'(out_col_reg);

endmodule

// ===== src/mmc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the column-major matrix multiply core, bound to its top level.
// Depends on mmc_pkg and matrix_multiply_colmajor_core.
module mmc_port_checks
    import mmc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] op,
    input logic       strobe,
    input logic       last
);

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_COMPUTE |=> busy)
        else $error("A compute item did not raise busy.");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("A result before the final one appeared while not busy.");

    a_last_strobed: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("The final mark appeared without a result.");

    a_busy_ends_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("Busy fell without the final result.");

    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("A result followed the final one at once.");

endmodule

bind matrix_multiply_colmajor_core mmc_port_checks u_mmc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .op     (op),
    .strobe (strobe),
    .last   (last)
);
